FILE: sv/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/c2p_pkg.sv
package c2p_pkg;

    // field widths
    localparam int COORD_W = 32;
    localparam int RADIUS_W = 32;
    localparam int ANGLE_W = 19;

    // datapath widths: cordic x/y, angle accumulator, square-root words
    localparam int CW = 51;
    localparam int ZW = 33;
    localparam int RW = 64;
    localparam int GUARD_BITS = 16;

    // one square-root bit per cell, so the chain is this long
    localparam int SQRT_STEPS = 32;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_STAGES_MAX = 32;

    // angle constants
    localparam int HALF_PI_Q30 = 1686629713;
    localparam int ROUND_Q30 = 8192;
    localparam int ANGLE_SHIFT = 14;
    localparam int ANGLE_PI = 205887;
    localparam int ANGLE_HALF_PI = 102944;
    localparam int ANGLE_MIN = -102944;
    localparam int ANGLE_MAX = 205887;

    // floor(atan(2^-i) * 2^30)
    localparam logic [31:0] ATAN_Q30 [CORDIC_STAGES_MAX] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd7,
        32'd3,         32'd1,         32'd0,         32'd0
    };

    // payload handed from cell to cell
    typedef struct packed {
        logic                      err;
        logic                      axis;
        logic                      neg;
        logic                      half;
        logic signed [ANGLE_W-1:0] axis_angle;
        logic [RW-1:0]             rem;
        logic [RW-1:0]             root;
        logic signed [CW-1:0]      px;
        logic signed [CW-1:0]      py;
        logic signed [ZW-1:0]      z;
    } stage_t;

endpackage

FILE: sv/cartesian_to_polar_top.sv
// cartesian to polar converter
// input channel: x_coord, y_coord (signed Q16.16) with in_valid / in_ready
// output channel: radius (unsigned Q16.16), angle (signed Q3.16 radians),
// domain_error, with out_valid / out_ready
// pipeline: two front stages for squaring and setup, 32 cells and one
// output register; throughput: one item per cycle unless the receiver
// stalls; each cell of the chain resolves one bit
// of the square root and one cordic rotation, the first CORDIC_STAGES
// cells rotate and the rest pass the angle along
// the third quadrant and the origin give domain_error with zero radius
// and zero angle
// a stalled receiver holds the output register; items keep entering while
// any slot of the chain is empty, bubbles close up, and in_ready drops only
// when every slot is full
// reset empties the chain; the data registers are not reset
module cartesian_to_polar_top #(
    parameter int CORDIC_STAGES = c2p_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [c2p_pkg::COORD_W-1:0]  x_coord,
    input  logic signed [c2p_pkg::COORD_W-1:0]  y_coord,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [c2p_pkg::RADIUS_W-1:0]        radius,
    output logic signed [c2p_pkg::ANGLE_W-1:0]  angle,
    output logic                                domain_error
);

    localparam int N = c2p_pkg::SQRT_STEPS;

    logic            chain_valid [N+1];
    c2p_pkg::stage_t chain_data  [N+1];
    logic            chain_ready [N+1];

    // front stages
    c2p_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .out_valid  (chain_valid[0]),
        .out_data   (chain_data[0]),
        .down_ready (chain_ready[0])
    );

    // chain of cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        c2p_cell #(
            .STAGE         (i),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (chain_valid[i]),
            .in_data    (chain_data[i]),
            .up_ready   (chain_ready[i]),
            .out_valid  (chain_valid[i+1]),
            .out_data   (chain_data[i+1]),
            .down_ready (chain_ready[i+1])
        );
    end

    // rounding and output register
    c2p_final u_final (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (chain_valid[N]),
        .in_data      (chain_data[N]),
        .up_ready     (chain_ready[N]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .radius       (radius),
        .angle        (angle),
        .domain_error (domain_error)
    );

endmodule

FILE: sv/c2p_prep.sv
module c2p_prep (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [c2p_pkg::COORD_W-1:0]   x_coord,
    input  logic signed [c2p_pkg::COORD_W-1:0]   y_coord,
    output logic                                 out_valid,
    output c2p_pkg::stage_t                      out_data,
    input  logic                                 down_ready
);

    localparam int W = c2p_pkg::COORD_W;
    localparam int AW = c2p_pkg::ANGLE_W;

    // first stage: classify and square
    logic                 a_valid_reg;
    logic                 a_err_reg, a_axis_reg, a_neg_reg, a_half_reg;
    logic signed [AW-1:0] a_angle_reg;
    logic [W-1:0]         a_a_reg, a_b_reg;
    logic [2*W-1:0]       a_sqx_reg, a_sqy_reg;

    logic                 b_valid_reg;
    c2p_pkg::stage_t      b_data_reg;
    c2p_pkg::stage_t      b_data_next;

    logic                 ready_a, ready_b;
    logic                 x_neg, y_neg, x_zero, y_zero;
    logic [W-1:0]         ax, ay;
    logic signed [AW-1:0] axis_angle;

    assign ready_b = !b_valid_reg || down_ready;
    assign ready_a = !a_valid_reg || ready_b;
    assign in_ready = ready_a;

    // quadrant decode
    assign x_neg  = x_coord[W-1];
    assign y_neg  = y_coord[W-1];
    assign x_zero = (x_coord == '0);
    assign y_zero = (y_coord == '0);
    assign ax = x_neg ? W'(-x_coord) : W'(x_coord);
    assign ay = y_neg ? W'(-y_coord) : W'(y_coord);

    // exact angles on the axes
    always_comb
    begin
        if (y_zero)
        begin
            axis_angle = x_neg ? AW'(c2p_pkg::ANGLE_PI) : '0;
        end
        else
        begin
            axis_angle = y_neg ? AW'(-c2p_pkg::ANGLE_HALF_PI) : AW'(c2p_pkg::ANGLE_HALF_PI);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (ready_a)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a)
        begin
            a_err_reg   <= (x_neg && y_neg) || (x_zero && y_zero);
            a_axis_reg  <= x_zero || y_zero;
            a_neg_reg   <= y_neg;
            a_half_reg  <= x_neg;
            a_angle_reg <= axis_angle;
            // left half plane is rotated a quarter turn clockwise
            a_a_reg     <= x_neg ? ay : ax;
            a_b_reg     <= x_neg ? ax : ay;
            a_sqx_reg   <= (2*W)'(ax) * (2*W)'(ax);
            a_sqy_reg   <= (2*W)'(ay) * (2*W)'(ay);
        end
    end

    // second stage: sum of squares and cordic start vector
    always_comb
    begin
        b_data_next            = '0;
        b_data_next.err        = a_err_reg;
        b_data_next.axis       = a_axis_reg;
        b_data_next.neg        = a_neg_reg;
        b_data_next.half       = a_half_reg;
        b_data_next.axis_angle = a_angle_reg;
        b_data_next.rem        = c2p_pkg::RW'(a_sqx_reg + a_sqy_reg);
        b_data_next.root       = '0;
        b_data_next.px         = c2p_pkg::CW'({a_a_reg, {c2p_pkg::GUARD_BITS{1'b0}}});
        b_data_next.py         = c2p_pkg::CW'({a_b_reg, {c2p_pkg::GUARD_BITS{1'b0}}});
        b_data_next.z          = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (ready_b)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_b)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

FILE: sv/c2p_cell.sv
module c2p_cell #(
    parameter int STAGE = 0,
    parameter int CORDIC_STAGES = c2p_pkg::CORDIC_STAGES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  c2p_pkg::stage_t in_data,
    output logic            up_ready,
    output logic            out_valid,
    output c2p_pkg::stage_t out_data,
    input  logic            down_ready
);

    localparam int RW = c2p_pkg::RW;
    localparam int ZW = c2p_pkg::ZW;
    localparam int CW = c2p_pkg::CW;
    localparam logic [RW-1:0] SQRT_BIT = RW'(1) << (RW - 2 - 2 * STAGE);
    localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(c2p_pkg::ATAN_Q30[STAGE]);
    localparam bit ROTATE = (STAGE < CORDIC_STAGES);

    logic            valid_reg;
    c2p_pkg::stage_t data_reg;
    c2p_pkg::stage_t data_next;

    logic [RW-1:0]        trial;
    logic [RW:0]          diff;
    logic signed [CW-1:0] dx, dy;

    assign up_ready = !valid_reg || down_ready;

    // one square-root digit and, in the first CORDIC_STAGES cells, one micro-rotation
    assign trial = in_data.root + SQRT_BIT;
    assign diff  = {1'b0, in_data.rem} - {1'b0, trial};
    assign dx    = in_data.py >>> STAGE;
    assign dy    = in_data.px >>> STAGE;

    always_comb
    begin
        data_next = in_data;
        if (!diff[RW])
        begin
            data_next.rem  = diff[RW-1:0];
            data_next.root = (in_data.root >> 1) + SQRT_BIT;
        end
        else
        begin
            data_next.root = in_data.root >> 1;
        end
        if (ROTATE)
        begin
            if (!in_data.py[CW-1])
            begin
                data_next.px = in_data.px + dx;
                data_next.py = in_data.py - dy;
                data_next.z  = in_data.z + ATAN_STEP;
            end
            else
            begin
                data_next.px = in_data.px - dx;
                data_next.py = in_data.py + dy;
                data_next.z  = in_data.z - ATAN_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/c2p_final.sv
module c2p_final (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  c2p_pkg::stage_t                     in_data,
    output logic                                up_ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [c2p_pkg::RADIUS_W-1:0]        radius,
    output logic signed [c2p_pkg::ANGLE_W-1:0]  angle,
    output logic                                domain_error
);

    localparam int SW = c2p_pkg::ZW + 2;
    localparam int AW = c2p_pkg::ANGLE_W;
    localparam int OW = c2p_pkg::RADIUS_W;
    localparam logic signed [SW-1:0] RND = SW'(c2p_pkg::ROUND_Q30);
    localparam logic signed [SW-1:0] RND_HALF =
        SW'(c2p_pkg::HALF_PI_Q30) + SW'(c2p_pkg::ROUND_Q30);
    localparam logic signed [SW-1:0] Q_MIN = SW'(c2p_pkg::ANGLE_MIN);
    localparam logic signed [SW-1:0] Q_MAX = SW'(c2p_pkg::ANGLE_MAX);

    logic                 valid_reg;
    logic [OW-1:0]        radius_reg, radius_next;
    logic signed [AW-1:0] angle_reg, angle_next;
    logic                 err_reg;

    logic signed [SW-1:0] z_ext, sum, q, q_clamp;

    assign up_ready = !valid_reg || out_ready;

    // angle offset, sign and rounding to Q3.16
    assign z_ext = SW'(in_data.z);
    always_comb
    begin
        if (in_data.neg)
        begin
            sum = RND - z_ext;
        end
        else if (in_data.half)
        begin
            sum = z_ext + RND_HALF;
        end
        else
        begin
            sum = z_ext + RND;
        end
    end
    assign q = sum >>> c2p_pkg::ANGLE_SHIFT;

    always_comb
    begin
        if (q < Q_MIN)
        begin
            q_clamp = Q_MIN;
        end
        else if (q > Q_MAX)
        begin
            q_clamp = Q_MAX;
        end
        else
        begin
            q_clamp = q;
        end
    end

    // result selection, radius rounded to nearest
    always_comb
    begin
        if (in_data.err)
        begin
            radius_next = '0;
            angle_next  = '0;
        end
        else
        begin
            radius_next = (in_data.rem > in_data.root) ? in_data.root[OW-1:0] + OW'(1)
                                                       : in_data.root[OW-1:0];
            angle_next  = in_data.axis ? in_data.axis_angle : q_clamp[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            radius_reg <= radius_next;
            angle_reg  <= angle_next;
            err_reg    <= in_data.err;
        end
    end

    assign out_valid    = valid_reg;
    assign radius       = radius_reg;
    assign angle        = angle_reg;
    assign domain_error = err_reg;

endmodule

FILE: sv/c2p_checker.sv
`include "assert_macros.svh"

module c2p_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic signed [c2p_pkg::COORD_W-1:0]  x_coord,
    input logic signed [c2p_pkg::COORD_W-1:0]  y_coord,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [c2p_pkg::RADIUS_W-1:0]        radius,
    input logic signed [c2p_pkg::ANGLE_W-1:0]  angle,
    input logic                                domain_error
);

    logic in_wait;
    logic out_stall;

    assign in_wait   = in_valid && !in_ready;
    assign out_stall = out_valid && !out_ready;

    // a waiting input item stays offered with its fields
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait,
        in_valid && $stable(x_coord) && $stable(y_coord),
        "input item changed while waiting")

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid,
        "result dropped while stalled")

    // a stalled result keeps its fields
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall,
        $stable(radius) && $stable(angle) && $stable(domain_error),
        "result changed while stalled")

    // an empty or draining output slot lets an item in
    `ASSERT_IMP(a_in_ready, clk, rst_n, !out_valid || out_ready, in_ready,
        "input blocked with free output slot")

    // an error result carries zero fields
    `ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && domain_error,
        (radius == '0) && (angle == '0), "error result with nonzero fields")

endmodule

bind cartesian_to_polar_top c2p_checker u_checker (.*);
